// ----- sv/mffd_pkg.sv -----
// Package for the motor feedback frame decoder: default parameters, frame
// field widths and the queue entry type shared by front, queue and back.
// No dependencies.
package mffd_pkg;

    // Default configuration of the block
    localparam int MOTOR_SLOTS_DEF    = 5;
    localparam int ENCODER_COUNTS_DEF = 8192;

    // Field widths
    localparam int ID_W      = 11;
    localparam int DLC_W     = 4;
    localparam int PAYLOAD_W = 56;
    localparam int NUM_W     = 8;
    localparam int SLOT_OUT_W = 3;
    localparam int ANGLE_W   = 16;
    localparam int WORD16_W  = 16;
    localparam int TEMP_W    = 8;
    localparam int TURNS_W   = 32;

    // Register reset and frame acceptance constants
    localparam logic [ID_W-1:0]  RX_BASE_ID_RESET = ID_W'(512);
    localparam logic [DLC_W-1:0] MIN_FRAME_LENGTH = DLC_W'(7);
    localparam logic [NUM_W-1:0] FIRST_SLOT_NUM   = NUM_W'(1);

    // Classified frame as held in the queue between front and back
    typedef struct packed {
        logic                       accepted;
        logic [NUM_W-1:0]           idx;
        logic [ANGLE_W-1:0]         angle;
        logic signed [WORD16_W-1:0] speed;
        logic signed [WORD16_W-1:0] drive_current;
        logic [TEMP_W-1:0]          temperature;
    } frame_t;

endpackage

// ----- sv/mffd_if.sv -----
// Handshake channels of the motor feedback frame decoder: received frame in,
// decoded feedback out. Depends on mffd_pkg for field widths.

interface mffd_frame_if;
    logic                              valid;
    logic                              ready;
    logic                              is_extended;
    logic                              is_remote;
    logic [mffd_pkg::DLC_W-1:0]        frame_length;
    logic [mffd_pkg::ID_W-1:0]         frame_id;
    logic [mffd_pkg::PAYLOAD_W-1:0]    payload;

    modport source (output valid, is_extended, is_remote, frame_length, frame_id, payload,
                    input ready);
    modport sink   (input valid, is_extended, is_remote, frame_length, frame_id, payload,
                    output ready);
endinterface

interface mffd_feedback_if;
    logic                                valid;
    logic                                ready;
    logic                                accepted;
    logic [mffd_pkg::SLOT_OUT_W-1:0]     slot;
    logic [mffd_pkg::ANGLE_W-1:0]        angle;
    logic signed [mffd_pkg::WORD16_W-1:0] speed;
    logic signed [mffd_pkg::WORD16_W-1:0] drive_current;
    logic [mffd_pkg::TEMP_W-1:0]         temperature;
    logic signed [mffd_pkg::TURNS_W-1:0] turns;
    logic signed [mffd_pkg::TURNS_W-1:0] total_position;

    modport source (output valid, accepted, slot, angle, speed, drive_current,
                    temperature, turns, total_position,
                    input ready);
    modport sink   (input valid, accepted, slot, angle, speed, drive_current,
                    temperature, turns, total_position,
                    output ready);
endinterface

// ----- sv/mffd_front.sv -----
// Front end: holds the base identifier register, filters each received frame
// and splits its payload into fields. Depends on mffd_pkg and mffd_frame_if.
module mffd_front #(
    parameter int MOTOR_SLOTS = mffd_pkg::MOTOR_SLOTS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [mffd_pkg::ID_W-1:0]   cfg_wdata,
    mffd_frame_if.sink                  frame,
    output logic                        push_valid,
    input  logic                        push_ready,
    output mffd_pkg::frame_t            push_data
);
    import mffd_pkg::*;

    logic [ID_W-1:0]  rx_base_id_reg;
    logic [ID_W-1:0]  id_diff;
    logic [NUM_W-1:0] slot_num;
    logic             hit;

    // Hold the base identifier; the user must write it only while the block is idle (not enforced here)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_base_id_reg <= RX_BASE_ID_RESET;
        end
        else if (cfg_we)
        begin
            rx_base_id_reg <= cfg_wdata;
        end
    end

    // Classify the frame: drop on format, length, identifier or slot range
    always_comb
    begin
        id_diff  = frame.frame_id - rx_base_id_reg;
        slot_num = id_diff[NUM_W-1:0];
        hit      = !frame.is_extended && !frame.is_remote
                   && (frame.frame_length >= MIN_FRAME_LENGTH)
                   && (frame.frame_id > rx_base_id_reg)
                   && (slot_num >= FIRST_SLOT_NUM)
                   && (slot_num <= NUM_W'(MOTOR_SLOTS));

        push_data = '0;
        if (hit)
        begin
            push_data.accepted      = 1'b1;
            push_data.idx           = slot_num - FIRST_SLOT_NUM;
            push_data.angle         = frame.payload[55:40];
            push_data.speed         = frame.payload[39:24];
            push_data.drive_current = frame.payload[23:8];
            push_data.temperature   = frame.payload[7:0];
        end
    end

    assign push_valid  = frame.valid;
    assign frame.ready = push_ready;

endmodule

// ----- sv/mffd_queue.sv -----
// Two-entry queue of classified frames between front and back, so each side
// can stall on its own. Depends on mffd_pkg.
module mffd_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  mffd_pkg::frame_t push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output mffd_pkg::frame_t pop_data
);
    import mffd_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    frame_t             entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Track fill level
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    // Store the beat
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- sv/mffd_back.sv -----
// Back end: per-slot angle unwrap into turn counters (read-modify-write in
// stage one) and total position product (stage two, output register).
// Depends on mffd_pkg and mffd_feedback_if.
module mffd_back #(
    parameter int MOTOR_SLOTS    = mffd_pkg::MOTOR_SLOTS_DEF,
    parameter int ENCODER_COUNTS = mffd_pkg::ENCODER_COUNTS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  mffd_pkg::frame_t pop_data,
    mffd_feedback_if.source  feedback
);
    import mffd_pkg::*;

    localparam int SLOT_W = (MOTOR_SLOTS > 1) ? $clog2(MOTOR_SLOTS) : 1;
    localparam int DELTA_W = ANGLE_W + 2;
    localparam logic signed [DELTA_W-1:0] HALF_COUNTS = DELTA_W'(ENCODER_COUNTS / 2);
    localparam logic [TURNS_W-1:0] COUNTS_WORD = TURNS_W'(ENCODER_COUNTS);

    // Per-slot state
    logic [ANGLE_W-1:0]  stored_angle_reg [MOTOR_SLOTS];
    logic [TURNS_W-1:0]  turn_counter_reg [MOTOR_SLOTS];
    logic [MOTOR_SLOTS-1:0] seen_reg;

    // Stage one
    logic                       s1_valid_reg;
    logic                       s1_accepted_reg;
    logic [SLOT_OUT_W-1:0]      s1_slot_reg;
    logic [ANGLE_W-1:0]         s1_angle_reg;
    logic signed [WORD16_W-1:0] s1_speed_reg;
    logic signed [WORD16_W-1:0] s1_current_reg;
    logic [TEMP_W-1:0]          s1_temp_reg;
    logic [TURNS_W-1:0]         s1_turns_reg;

    // Stage two (output register)
    logic                       s2_valid_reg;
    logic                       s2_accepted_reg;
    logic [SLOT_OUT_W-1:0]      s2_slot_reg;
    logic [ANGLE_W-1:0]         s2_angle_reg;
    logic signed [WORD16_W-1:0] s2_speed_reg;
    logic signed [WORD16_W-1:0] s2_current_reg;
    logic [TEMP_W-1:0]          s2_temp_reg;
    logic [TURNS_W-1:0]         s2_turns_reg;
    logic [TURNS_W-1:0]         s2_total_reg;

    logic                       adv2;
    logic                       adv1;
    logic                       take;
    logic                       update;
    logic [SLOT_W-1:0]          idx;
    logic [ANGLE_W-1:0]         prev_angle;
    logic [TURNS_W-1:0]         prev_turns;
    logic signed [DELTA_W-1:0]  delta;
    logic [TURNS_W-1:0]         turns_next;
    logic [TURNS_W-1:0]         product;

    assign adv2      = !s2_valid_reg || feedback.ready;
    assign adv1      = !s1_valid_reg || adv2;
    assign pop_ready = adv1;
    assign take      = pop_valid && adv1;
    assign update    = take && pop_data.accepted;
    assign idx       = pop_data.idx[SLOT_W-1:0];

    // Unwrap the angle step into the slot's turn counter
    always_comb
    begin
        prev_angle = stored_angle_reg[idx];
        prev_turns = turn_counter_reg[idx];
        delta      = DELTA_W'(pop_data.angle) - DELTA_W'(prev_angle);
        turns_next = prev_turns;
        if (seen_reg[idx])
        begin
            if (delta > HALF_COUNTS)
            begin
                turns_next = prev_turns - TURNS_W'(1);
            end
            else if (delta < -HALF_COUNTS)
            begin
                turns_next = prev_turns + TURNS_W'(1);
            end
        end
    end

    // Write back slot state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
            for (int k = 0; k < MOTOR_SLOTS; k++)
            begin
                stored_angle_reg[k] <= '0;
                turn_counter_reg[k] <= '0;
            end
        end
        else if (update)
        begin
            seen_reg[idx]         <= 1'b1;
            stored_angle_reg[idx] <= pop_data.angle;
            turn_counter_reg[idx] <= turns_next;
        end
    end

    // Stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_valid_reg <= pop_valid;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Stage one payload; a dropped frame carries zero turns
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_accepted_reg <= pop_data.accepted;
            s1_slot_reg     <= pop_data.idx[SLOT_OUT_W-1:0];
            s1_angle_reg    <= pop_data.angle;
            s1_speed_reg    <= pop_data.speed;
            s1_current_reg  <= pop_data.drive_current;
            s1_temp_reg     <= pop_data.temperature;
            s1_turns_reg    <= pop_data.accepted ? turns_next : '0;
        end
    end

    // Total position: turns scaled by the encoder range plus the raw angle
    assign product = TURNS_W'(s1_turns_reg * COUNTS_WORD);

    always_ff @(posedge clk)
    begin
        if (adv2 && s1_valid_reg)
        begin
            s2_accepted_reg <= s1_accepted_reg;
            s2_slot_reg     <= s1_slot_reg;
            s2_angle_reg    <= s1_angle_reg;
            s2_speed_reg    <= s1_speed_reg;
            s2_current_reg  <= s1_current_reg;
            s2_temp_reg     <= s1_temp_reg;
            s2_turns_reg    <= s1_turns_reg;
            s2_total_reg    <= product + TURNS_W'(s1_angle_reg);
        end
    end

    assign feedback.valid          = s2_valid_reg;
    assign feedback.accepted       = s2_accepted_reg;
    assign feedback.slot           = s2_slot_reg;
    assign feedback.angle          = s2_angle_reg;
    assign feedback.speed          = s2_speed_reg;
    assign feedback.drive_current  = s2_current_reg;
    assign feedback.temperature    = s2_temp_reg;
    assign feedback.turns          = s2_turns_reg;
    assign feedback.total_position = s2_total_reg;

endmodule

// ----- sv/motor_feedback_frame_decoder_top.sv -----
// Motor feedback frame decoder. Takes one received CAN frame per beat and
// returns exactly one feedback beat for it: accepted with the decoded angle,
// speed, current, temperature, turn count and total position, or all zero
// when the frame is dropped (extended, remote, short, or outside the slot
// range above rx_base_id). Sustained rate is one frame per clock cycle while
// the output is ready; the feedback beat is registered through the queue entry
// register, the per-slot unwrap stage and the position multiply stage. The
// input stalls only when the two-entry queue is full behind a stalled output.
// Per-slot state resets to not-yet-seen; rx_base_id is written through
// cfg_we/cfg_wdata, and the user must write it only while no frame is in
// flight; the block itself does not enforce this.
// Depends on mffd_pkg, mffd_if, mffd_front, mffd_queue and mffd_back.
module motor_feedback_frame_decoder_top #(
    parameter int MOTOR_SLOTS    = mffd_pkg::MOTOR_SLOTS_DEF,
    parameter int ENCODER_COUNTS = mffd_pkg::ENCODER_COUNTS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [mffd_pkg::ID_W-1:0]   cfg_wdata,
    mffd_frame_if.sink                  frame,
    mffd_feedback_if.source             feedback
);
    import mffd_pkg::*;

    logic   push_valid;
    logic   push_ready;
    frame_t push_data;
    logic   pop_valid;
    logic   pop_ready;
    frame_t pop_data;

    // Filter and split incoming frames
    mffd_front #(
        .MOTOR_SLOTS (MOTOR_SLOTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .frame      (frame),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Decouple front from back
    mffd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Unwrap and position
    mffd_back #(
        .MOTOR_SLOTS    (MOTOR_SLOTS),
        .ENCODER_COUNTS (ENCODER_COUNTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .feedback  (feedback)
    );

endmodule

// ----- bench/tb_motor_feedback_frame_decoder_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench for motor_feedback_frame_decoder_top: directed frames, then random
// frame streams under several rx_base_id settings, checked beat by beat against a predictor.
// Depends on mffd_pkg, mffd_if and the decoder RTL.
module tb_motor_feedback_frame_decoder_top;
    import mffd_pkg::*;

    localparam int SLOTS           = MOTOR_SLOTS_DEF;
    localparam int COUNTS          = ENCODER_COUNTS_DEF;
    localparam int HALF            = COUNTS / 2;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int HOLD_OFF        = 400;
    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 225;
    localparam int MAX_REPORTS     = 40;

    typedef struct packed {
        logic                 ext;
        logic                 rtr;
        logic [DLC_W-1:0]     dlc;
        logic [ID_W-1:0]      id;
        logic [PAYLOAD_W-1:0] payload;
    } can_frame_t;

    typedef struct packed {
        logic                       accepted;
        logic [SLOT_OUT_W-1:0]      slot;
        logic [ANGLE_W-1:0]         angle;
        logic signed [WORD16_W-1:0] speed;
        logic signed [WORD16_W-1:0] drive_current;
        logic [TEMP_W-1:0]          temperature;
        logic signed [TURNS_W-1:0]  turns;
        logic signed [TURNS_W-1:0]  total_position;
    } feedback_t;

    typedef struct {
        can_frame_t frm;
        bit         typed;
        feedback_t  fb;
    } stim_row_t;

    localparam feedback_t DROPPED = '0;

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            cfg_we    = 1'b0;
    logic [ID_W-1:0] cfg_wdata = RX_BASE_ID_RESET;

    mffd_frame_if    frame_ch ();
    mffd_feedback_if fb_ch ();

    motor_feedback_frame_decoder_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .frame     (frame_ch),
        .feedback  (fb_ch)
    );

    // Predictor state: register copy and per-slot unwrap state
    logic [ID_W-1:0]    base_id;
    logic [ANGLE_W-1:0] last_angle [SLOTS];
    logic [TURNS_W-1:0] turn_count [SLOTS];
    bit                 slot_seen  [SLOTS];

    // Generator's own view of each slot's angle, to build plausible rotation
    logic [ANGLE_W-1:0] gen_angle [SLOTS];

    feedback_t feedback_due [$];
    stim_row_t directed [$];
    int        errors        = 0;
    int        cycles        = 0;
    int        hold_requests = 0;

    always #4 clk = ~clk;

    // Decode one frame and advance the slot's turn counter
    function automatic feedback_t decode_frame(can_frame_t f);
        feedback_t         r;
        logic [ID_W-1:0]   diff;
        logic [NUM_W-1:0]  num;
        logic [ANGLE_W-1:0] ang;
        int                k;
        int                step;
        r = '0;
        if (f.ext || f.rtr || f.dlc < MIN_FRAME_LENGTH || f.id <= base_id)
            return r;
        diff = f.id - base_id;
        num  = diff[NUM_W-1:0];
        if (num < FIRST_SLOT_NUM || num > NUM_W'(SLOTS))
            return r;
        k   = int'(num) - 1;
        ang = f.payload[55:40];
        if (slot_seen[k])
        begin
            step = int'(ang) - int'(last_angle[k]);
            if (step > HALF)
                turn_count[k] -= 1;
            else if (step < -HALF)
                turn_count[k] += 1;
        end
        last_angle[k] = ang;
        slot_seen[k]  = 1'b1;
        r.accepted       = 1'b1;
        r.slot           = k[SLOT_OUT_W-1:0];
        r.angle          = ang;
        r.speed          = f.payload[39:24];
        r.drive_current  = f.payload[23:8];
        r.temperature    = f.payload[7:0];
        r.turns          = turn_count[k];
        r.total_position = turn_count[k] * TURNS_W'(COUNTS) + TURNS_W'(ang);
        return r;
    endfunction

    function automatic logic [PAYLOAD_W-1:0] pack_payload(int ang, int spd, int cur, int tmp);
        return {16'(ang), 16'(spd), 16'(cur), 8'(tmp)};
    endfunction

    function automatic can_frame_t mk_frame(int ext, int rtr, int dlc, int id,
                                            logic [PAYLOAD_W-1:0] pl);
        can_frame_t f;
        f.ext     = 1'(ext);
        f.rtr     = 1'(rtr);
        f.dlc     = DLC_W'(dlc);
        f.id      = ID_W'(id);
        f.payload = pl;
        return f;
    endfunction

    function automatic feedback_t mk_fb(int slot, int ang, int spd, int cur, int tmp,
                                        int turns, int total);
        feedback_t r;
        r.accepted       = 1'b1;
        r.slot           = SLOT_OUT_W'(slot);
        r.angle          = ANGLE_W'(ang);
        r.speed          = WORD16_W'(spd);
        r.drive_current  = WORD16_W'(cur);
        r.temperature    = TEMP_W'(tmp);
        r.turns          = TURNS_W'(turns);
        r.total_position = TURNS_W'(total);
        return r;
    endfunction

    // Mostly well-formed feedback for a live slot, the rest noise
    function automatic can_frame_t gen_frame();
        can_frame_t         f;
        logic [ANGLE_W-1:0] ang;
        int                 r;
        int                 num;
        int                 mode;
        int                 step;
        r         = $urandom_range(0, 99);
        f.payload = PAYLOAD_W'({$urandom, $urandom});
        if (r < 78)
        begin
            num   = $urandom_range(1, SLOTS);
            f.ext = 1'b0;
            f.rtr = 1'b0;
            f.dlc = ($urandom_range(0, 3) == 0) ? DLC_W'($urandom_range(7, 15)) : DLC_W'(8);
            f.id  = base_id + ID_W'(num);
            if ($urandom_range(0, 9) == 0)
                f.id = f.id + ID_W'(256 * $urandom_range(1, 7));
            mode = $urandom_range(0, 9);
            step = 0;
            if (mode < 5)
                step = int'($urandom_range(0, 600)) - 300;
            else if (mode < 7)
                step = HALF - 4 + int'($urandom_range(0, 8));
            if (mode == 6)
                step = -step;
            ang = ANGLE_W'((((int'(gen_angle[num-1]) + step) % COUNTS) + COUNTS) % COUNTS);
            if (mode == 7)
                ang = $urandom_range(0, 1) ? ANGLE_W'($urandom_range(0, 40))
                                           : ANGLE_W'(COUNTS - 1 - $urandom_range(0, 40));
            else if (mode == 8)
                ang = ANGLE_W'($urandom);
            else if (mode == 9)
                ang = ANGLE_W'($urandom_range(0, COUNTS - 1));
            gen_angle[num-1] = ang;
            f.payload[55:40] = ang;
        end
        else
        begin
            f.ext = ($urandom_range(0, 3) == 0);
            f.rtr = ($urandom_range(0, 3) == 0);
            f.dlc = DLC_W'($urandom);
            f.id  = (r < 90) ? ID_W'($urandom) : base_id + ID_W'($urandom_range(0, 8));
        end
        return f;
    endfunction

    // Short gaps mostly, a few long ones
    function automatic int pick_gap(bit burst);
        int r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one frame beat and queue what it should produce once taken
    task automatic send_frame(can_frame_t f, int gap, bit typed, feedback_t fb);
        feedback_t due;
        if (gap > 0)
        begin
            frame_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        frame_ch.valid        <= 1'b1;
        frame_ch.is_extended  <= f.ext;
        frame_ch.is_remote    <= f.rtr;
        frame_ch.frame_length <= f.dlc;
        frame_ch.frame_id     <= f.id;
        frame_ch.payload      <= f.payload;
        do
            @(posedge clk);
        while (frame_ch.ready !== 1'b1);
        due = decode_frame(f);
        feedback_due.push_back(typed ? fb : due);
    endtask

    // Hold the input idle until every expected beat is back
    task automatic drain(int settle);
        frame_ch.valid <= 1'b0;
        while (feedback_due.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_base(logic [ID_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        base_id    = v;
    endtask

    task automatic check_field(string name, logic signed [63:0] e, logic signed [63:0] a);
        if (a !== e)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
        end
    endtask

    // Main sequence: reset, directed table, then random phases
    initial
    begin
        int        p;
        int        n;
        bit        burst;
        stim_row_t row;
        frame_ch.valid        <= 1'b0;
        frame_ch.is_extended  <= 1'b0;
        frame_ch.is_remote    <= 1'b0;
        frame_ch.frame_length <= '0;
        frame_ch.frame_id     <= '0;
        frame_ch.payload      <= '0;
        base_id = RX_BASE_ID_RESET;
        for (int k = 0; k < SLOTS; k++)
        begin
            last_angle[k] = '0;
            turn_count[k] = '0;
            slot_seen[k]  = 1'b0;
            gen_angle[k]  = '0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Drops: extended, remote, short, at or below base, slot out of range
        directed.push_back('{mk_frame(1, 0, 8, 513, '1), 1'b1, DROPPED});
        directed.push_back('{mk_frame(0, 1, 8, 513, '1), 1'b1, DROPPED});
        directed.push_back('{mk_frame(0, 0, 6, 513, '1), 1'b1, DROPPED});
        directed.push_back('{mk_frame(0, 0, 0, 514, '1), 1'b1, DROPPED});
        directed.push_back('{mk_frame(0, 0, 8, 512, '1), 1'b1, DROPPED});
        directed.push_back('{mk_frame(0, 0, 8, 0, '1), 1'b1, DROPPED});
        directed.push_back('{mk_frame(0, 0, 8, 518, '1), 1'b1, DROPPED});
        directed.push_back('{mk_frame(0, 0, 8, 2047, '1), 1'b1, DROPPED});
        directed.push_back('{mk_frame(1, 1, 15, 515, '1), 1'b1, DROPPED});
        // First sight of a slot: no unwrap
        directed.push_back('{mk_frame(0, 0, 8, 513, '1), 1'b1,
                             mk_fb(0, 65535, -1, -1, 255, 0, 65535)});
        directed.push_back('{mk_frame(0, 0, 7, 517, '0), 1'b1, mk_fb(4, 0, 0, 0, 0, 0, 0)});
        directed.push_back('{mk_frame(0, 0, 15, 514, pack_payload(100, 16'h7FFF, 16'h8000, 0)),
                             1'b1, mk_fb(1, 100, 32767, -32768, 0, 0, 100)});
        // Slot number taken modulo 256, then unwrap steps around half a turn
        directed.push_back('{mk_frame(0, 0, 8, 769, pack_payload(0, 1, 2, 3)), 1'b0, DROPPED});
        directed.push_back('{mk_frame(0, 0, 8, 513, pack_payload(HALF, 4, 5, 6)), 1'b0,
                             DROPPED});
        directed.push_back('{mk_frame(0, 0, 8, 513, pack_payload(0, 7, 8, 9)), 1'b0, DROPPED});
        directed.push_back('{mk_frame(0, 0, 8, 513, pack_payload(COUNTS - 1, 0, 0, 0)), 1'b0,
                             DROPPED});
        directed.push_back('{mk_frame(0, 0, 8, 513, pack_payload(0, 0, 0, 0)), 1'b0, DROPPED});
        directed.push_back('{mk_frame(0, 0, 8, 515, pack_payload(9000, 0, 0, 0)), 1'b0,
                             DROPPED});
        directed.push_back('{mk_frame(0, 0, 8, 516, pack_payload(HALF + 1, 0, 0, 0)), 1'b0,
                             DROPPED});
        directed.push_back('{mk_frame(0, 0, 8, 516, pack_payload(0, 0, 0, 0)), 1'b0, DROPPED});
        directed.push_back('{mk_frame(0, 0, 9, 1025, PAYLOAD_W'({$urandom, $urandom})), 1'b0,
                             DROPPED});

        // Walk the directed table
        for (int i = 0; i < directed.size(); i++)
        begin
            row = directed[i];
            send_frame(row.frm, pick_gap(1'b0), row.typed, row.fb);
        end

        // Random phases, each under its own base identifier
        for (p = 0; p < NUM_PHASES; p++)
        begin
            if (p > 0)
            begin
                drain(8);
                case (p)
                    1: write_base('0);
                    2: write_base('1);
                    3: write_base(ID_W'(2042));
                    4: write_base(ID_W'($urandom));
                    default: write_base(ID_W'($urandom_range(1500, 2040)));
                endcase
            end
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // Stall the output for a long stretch while frames keep coming
                if (p == 1 && n == 100)
                begin
                    drain(0);
                    hold_requests++;
                end
                burst = (n % 75) >= 60 || (p == 1 && n >= 100 && n < 160);
                send_frame(gen_frame(), pick_gap(burst), 1'b0, DROPPED);
            end
        end

        drain(20);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Output ready: random runs, plus a counted hold-off on request
    initial
    begin
        int  run_left;
        int  r;
        bit  level;
        int  hold_left;
        int  hold_served;
        run_left    = 0;
        level       = 1'b0;
        hold_left   = 0;
        hold_served = 0;
        fb_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != hold_served)
            begin
                hold_served = hold_requests;
                hold_left   = HOLD_OFF;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                fb_ch.ready <= 1'b0;
            end
            else
            begin
                if (run_left == 0)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 50)
                    begin
                        level    = 1'b1;
                        run_left = $urandom_range(1, 8);
                    end
                    else if (r < 85)
                    begin
                        level    = 1'b0;
                        run_left = $urandom_range(1, 3);
                    end
                    else if (r < 95)
                    begin
                        level    = 1'b0;
                        run_left = $urandom_range(10, 50);
                    end
                    else
                    begin
                        level    = 1'b1;
                        run_left = $urandom_range(50, 150);
                    end
                end
                run_left--;
                fb_ch.ready <= level;
            end
        end
    end

    // Compare each feedback beat with the oldest expectation
    always @(posedge clk)
    begin
        feedback_t due;
        if (rst_n && fb_ch.valid === 1'b1 && fb_ch.ready === 1'b1)
        begin
            if (feedback_due.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: feedback beat with nothing expected, expected none, actual %h",
                             $time, {fb_ch.accepted, fb_ch.slot, fb_ch.angle});
            end
            else
            begin
                due = feedback_due.pop_front();
                check_field("accepted", 64'(due.accepted), 64'(fb_ch.accepted));
                check_field("slot", 64'(due.slot), 64'(fb_ch.slot));
                check_field("angle", 64'(due.angle), 64'(fb_ch.angle));
                check_field("speed", 64'(due.speed), 64'(fb_ch.speed));
                check_field("drive_current", 64'(due.drive_current),
                            64'(fb_ch.drive_current));
                check_field("temperature", 64'(due.temperature), 64'(fb_ch.temperature));
                check_field("turns", 64'(due.turns), 64'(fb_ch.turns));
                check_field("total_position", 64'(due.total_position),
                            64'(fb_ch.total_position));
            end
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule
